### design/oriented_rect_overlap_sat_assert.svh
// ---------------------------------------------------------------------------
// oriented_rect_overlap_sat assertion macros
// Concurrent assertion wrappers clocked on i_clk; ASSERT_OFF removes them.
// ---------------------------------------------------------------------------
`ifndef ORIENTED_RECT_OVERLAP_SAT_ASSERT_SVH
`define ORIENTED_RECT_OVERLAP_SAT_ASSERT_SVH

`ifndef ASSERT_OFF

// checked outside reset only
`define ORS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("oriented_rect_overlap_sat: assertion failed");

// checked at every edge, reset included
`define ORS_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("oriented_rect_overlap_sat: reset assertion failed");

`else

`define ORS_ASSERT(lbl, prop)
`define ORS_ASSERT_RST(lbl, prop)

`endif

`endif

### design/ors_pkg.sv
// ---------------------------------------------------------------------------
// ors_pkg
// Shared defaults for the oriented rectangle overlap pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ors_pkg;

    // centre / half size width (Q.8, signed centres)
    localparam int COORD_BITS_DEF     = 24;
    // fraction bits of an axis component (component is F+2 bits signed)
    localparam int AXIS_FRAC_BITS_DEF = 14;

endpackage

### design/ors_dot_unit.sv
// ---------------------------------------------------------------------------
// ors_dot_unit
// Stages 1 and 2: centre difference, axis-to-axis dot products with rounded
// magnitudes, and the partial products of the centre projections.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "oriented_rect_overlap_sat_assert.svh"

module ors_dot_unit #(
    parameter int COORD_BITS     = ors_pkg::COORD_BITS_DEF,
    parameter int AXIS_FRAC_BITS = ors_pkg::AXIS_FRAC_BITS_DEF,
    localparam int CW = COORD_BITS,
    localparam int HW = COORD_BITS - 1,
    localparam int AW = AXIS_FRAC_BITS + 2,
    localparam int DW = COORD_BITS + 1,
    localparam int MW = DW + AW,
    localparam int RW = AXIS_FRAC_BITS + 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [CW-1:0] i_acx,
    input  logic signed [CW-1:0] i_acy,
    input  logic        [HW-1:0] i_ahw,
    input  logic        [HW-1:0] i_ahh,
    input  logic signed [AW-1:0] i_ac,
    input  logic signed [AW-1:0] i_as,
    input  logic signed [CW-1:0] i_bcx,
    input  logic signed [CW-1:0] i_bcy,
    input  logic        [HW-1:0] i_bhw,
    input  logic        [HW-1:0] i_bhh,
    input  logic signed [AW-1:0] i_bc,
    input  logic signed [AW-1:0] i_bs,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic        [HW-1:0] o_ahw,
    output logic        [HW-1:0] o_ahh,
    output logic        [HW-1:0] o_bhw,
    output logic        [HW-1:0] o_bhh,
    output logic        [RW-1:0] o_rna,
    output logic        [RW-1:0] o_rnb,
    output logic        [RW-1:0] o_rp,
    output logic        [RW-1:0] o_rq,
    output logic signed [MW-1:0] o_m_dxac,
    output logic signed [MW-1:0] o_m_dyas,
    output logic signed [MW-1:0] o_m_dxas,
    output logic signed [MW-1:0] o_m_dyac,
    output logic signed [MW-1:0] o_m_dxbc,
    output logic signed [MW-1:0] o_m_dybs,
    output logic signed [MW-1:0] o_m_dxbs,
    output logic signed [MW-1:0] o_m_dybc
);

    localparam int PW = 2 * AW;
    localparam logic [PW:0]   RHALF = (PW + 1)'(1) << (AXIS_FRAC_BITS - 1);
    localparam logic [RW-1:0] RMAX  = RW'(1) << (AXIS_FRAC_BITS + 3);

    // |d| rounded half up to scale 2^F
    function automatic logic [RW-1:0] round_abs(input logic signed [PW:0] d);
        logic [PW:0] a;
        logic [PW:0] t;
        a = $unsigned(d[PW] ? -d : d);
        t = a + RHALF;
        return t[AXIS_FRAC_BITS +: RW];
    endfunction

    // stage enables, bubbles collapse
    logic w_en1, w_en2;
    logic r_v1, r_v2;

    assign w_en2   = !r_v2 || i_ready;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;
    assign o_valid = r_v2;

    // stage 1 registers
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [AW-1:0] r_ac, r_as, r_bc, r_bs;
    logic signed [PW-1:0] r_pacac, r_pasas, r_pbcbc, r_pbsbs;
    logic signed [PW-1:0] r_pacbc, r_pasbs, r_pasbc, r_pacbs;
    logic        [HW-1:0] r1_ahw, r1_ahh, r1_bhw, r1_bhh;

    // stage 2 registers
    logic        [RW-1:0] r_rna, r_rnb, r_rp, r_rq;
    logic        [HW-1:0] r2_ahw, r2_ahh, r2_bhw, r2_bhh;
    logic signed [MW-1:0] r_m_dxac, r_m_dyas, r_m_dxas, r_m_dyac;
    logic signed [MW-1:0] r_m_dxbc, r_m_dybs, r_m_dxbs, r_m_dybc;

    // dot sums; a.x.a.y and b.x.b.y are identically zero
    logic signed [PW:0] w_na, w_nb, w_p, w_q;

    always_comb begin
        w_na = (PW + 1)'(r_pacac) + (PW + 1)'(r_pasas);
        w_nb = (PW + 1)'(r_pbcbc) + (PW + 1)'(r_pbsbs);
        w_p  = (PW + 1)'(r_pacbc) + (PW + 1)'(r_pasbs);
        w_q  = (PW + 1)'(r_pasbc) - (PW + 1)'(r_pacbs);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
        end
    end

    // stage 1: centre difference and axis products
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_dx    <= DW'(i_acx) - DW'(i_bcx);
            r_dy    <= DW'(i_acy) - DW'(i_bcy);
            r_ac    <= i_ac;
            r_as    <= i_as;
            r_bc    <= i_bc;
            r_bs    <= i_bs;
            r_pacac <= PW'(i_ac) * PW'(i_ac);
            r_pasas <= PW'(i_as) * PW'(i_as);
            r_pbcbc <= PW'(i_bc) * PW'(i_bc);
            r_pbsbs <= PW'(i_bs) * PW'(i_bs);
            r_pacbc <= PW'(i_ac) * PW'(i_bc);
            r_pasbs <= PW'(i_as) * PW'(i_bs);
            r_pasbc <= PW'(i_as) * PW'(i_bc);
            r_pacbs <= PW'(i_ac) * PW'(i_bs);
            r1_ahw  <= i_ahw;
            r1_ahh  <= i_ahh;
            r1_bhw  <= i_bhw;
            r1_bhh  <= i_bhh;
        end
    end

    // stage 2: rounded dot magnitudes, projection partial products
    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_rna    <= round_abs(w_na);
            r_rnb    <= round_abs(w_nb);
            r_rp     <= round_abs(w_p);
            r_rq     <= round_abs(w_q);
            r_m_dxac <= MW'(r_dx) * MW'(r_ac);
            r_m_dyas <= MW'(r_dy) * MW'(r_as);
            r_m_dxas <= MW'(r_dx) * MW'(r_as);
            r_m_dyac <= MW'(r_dy) * MW'(r_ac);
            r_m_dxbc <= MW'(r_dx) * MW'(r_bc);
            r_m_dybs <= MW'(r_dy) * MW'(r_bs);
            r_m_dxbs <= MW'(r_dx) * MW'(r_bs);
            r_m_dybc <= MW'(r_dy) * MW'(r_bc);
            r2_ahw   <= r1_ahw;
            r2_ahh   <= r1_ahh;
            r2_bhw   <= r1_bhw;
            r2_bhh   <= r1_bhh;
        end
    end

    assign o_rna    = r_rna;
    assign o_rnb    = r_rnb;
    assign o_rp     = r_rp;
    assign o_rq     = r_rq;
    assign o_ahw    = r2_ahw;
    assign o_ahh    = r2_ahh;
    assign o_bhw    = r2_bhw;
    assign o_bhh    = r2_bhh;
    assign o_m_dxac = r_m_dxac;
    assign o_m_dyas = r_m_dyas;
    assign o_m_dxas = r_m_dxas;
    assign o_m_dyac = r_m_dyac;
    assign o_m_dxbc = r_m_dxbc;
    assign o_m_dybs = r_m_dybs;
    assign o_m_dxbs = r_m_dxbs;
    assign o_m_dybc = r_m_dybc;

    // checks
    `ORS_ASSERT(a_accept_lands, i_valid && o_ready |=> r_v1)
    `ORS_ASSERT(a_rna_bound, r_v2 |-> (r_rna <= RMAX) && (r_rnb <= RMAX))
    `ORS_ASSERT_RST(a_reset_clears, !i_rst_n |=> !r_v1 && !r_v2)

endmodule

### design/ors_sep_unit.sv
// ---------------------------------------------------------------------------
// ors_sep_unit
// Stages 3 and 4: projected centre distances, radius products, radius sums
// and the separating-axis compare into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "oriented_rect_overlap_sat_assert.svh"

module ors_sep_unit #(
    parameter int COORD_BITS     = ors_pkg::COORD_BITS_DEF,
    parameter int AXIS_FRAC_BITS = ors_pkg::AXIS_FRAC_BITS_DEF,
    localparam int HW = COORD_BITS - 1,
    localparam int AW = AXIS_FRAC_BITS + 2,
    localparam int DW = COORD_BITS + 1,
    localparam int MW = DW + AW,
    localparam int RW = AXIS_FRAC_BITS + 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic        [HW-1:0] i_ahw,
    input  logic        [HW-1:0] i_ahh,
    input  logic        [HW-1:0] i_bhw,
    input  logic        [HW-1:0] i_bhh,
    input  logic        [RW-1:0] i_rna,
    input  logic        [RW-1:0] i_rnb,
    input  logic        [RW-1:0] i_rp,
    input  logic        [RW-1:0] i_rq,
    input  logic signed [MW-1:0] i_m_dxac,
    input  logic signed [MW-1:0] i_m_dyas,
    input  logic signed [MW-1:0] i_m_dxas,
    input  logic signed [MW-1:0] i_m_dyac,
    input  logic signed [MW-1:0] i_m_dxbc,
    input  logic signed [MW-1:0] i_m_dybs,
    input  logic signed [MW-1:0] i_m_dxbs,
    input  logic signed [MW-1:0] i_m_dybc,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_overlap
);

    localparam int QW = HW + RW;
    localparam int SW = QW + 3;

    logic w_en3, w_en_out;
    logic r_v3, r_out_v;

    assign w_en_out = !r_out_v || i_ready;
    assign w_en3    = !r_v3 || w_en_out;
    assign o_ready  = w_en3;
    assign o_valid  = r_out_v;

    // projected centre difference on a.x, a.y, b.x, b.y
    logic signed [MW:0] w_proj [0:3];
    logic        [MW:0] w_dist [0:3];

    always_comb begin
        w_proj[0] = (MW + 1)'(i_m_dxac) + (MW + 1)'(i_m_dyas);
        w_proj[1] = (MW + 1)'(i_m_dyac) - (MW + 1)'(i_m_dxas);
        w_proj[2] = (MW + 1)'(i_m_dxbc) + (MW + 1)'(i_m_dybs);
        w_proj[3] = (MW + 1)'(i_m_dybc) - (MW + 1)'(i_m_dxbs);
        for (int k = 0; k < 4; k++) begin
            w_dist[k] = $unsigned(w_proj[k][MW] ? -w_proj[k] : w_proj[k]);
        end
    end

    logic [MW:0]   r_dist [0:3];
    logic [QW-1:0] r_rad  [0:3][0:2];
    logic          r_overlap;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en3)    r_v3    <= i_valid;
            if (w_en_out) r_out_v <= r_v3;
        end
    end

    // stage 3: distances and radius terms (self cross term is zero)
    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            for (int k = 0; k < 4; k++) begin
                r_dist[k] <= w_dist[k];
            end
            r_rad[0][0] <= QW'(i_ahw) * QW'(i_rna);
            r_rad[0][1] <= QW'(i_bhw) * QW'(i_rp);
            r_rad[0][2] <= QW'(i_bhh) * QW'(i_rq);
            r_rad[1][0] <= QW'(i_ahh) * QW'(i_rna);
            r_rad[1][1] <= QW'(i_bhw) * QW'(i_rq);
            r_rad[1][2] <= QW'(i_bhh) * QW'(i_rp);
            r_rad[2][0] <= QW'(i_ahw) * QW'(i_rp);
            r_rad[2][1] <= QW'(i_ahh) * QW'(i_rq);
            r_rad[2][2] <= QW'(i_bhw) * QW'(i_rnb);
            r_rad[3][0] <= QW'(i_ahw) * QW'(i_rq);
            r_rad[3][1] <= QW'(i_ahh) * QW'(i_rp);
            r_rad[3][2] <= QW'(i_bhh) * QW'(i_rnb);
        end
    end

    // stage 4: radius sums and strict compare per axis
    logic [SW-1:0] w_rsum [0:3];
    logic [3:0]    w_sep;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_rsum[k] = SW'(r_rad[k][0]) + SW'(r_rad[k][1]) + SW'(r_rad[k][2]);
            w_sep[k]  = SW'(r_dist[k]) > w_rsum[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_overlap <= ~|w_sep;
        end
    end

    assign o_overlap = r_overlap;

    // checks
    `ORS_ASSERT_RST(a_out_reset, !i_rst_n |=> !o_valid)
    `ORS_ASSERT(a_s3_hold, r_v3 && !w_en3 |=> r_v3 && $stable(r_dist[0]))
    `ORS_ASSERT(a_s3_moves, r_v3 && w_en_out |=> o_valid)

endmodule

### design/oriented_rect_overlap_sat.sv
// ---------------------------------------------------------------------------
// oriented_rect_overlap_sat
// Separating axis overlap test of two oriented rectangles, streaming.
// ---------------------------------------------------------------------------
// One word in carries two rectangles (centre, half width, half height, unit
// x axis); one word out carries the overlap flag, 1 unless one of the four
// rectangle axes separates them (touching counts as overlap). The pipeline
// takes one word per cycle unless output back-pressure stalls it, and has
// four register stages; the depth is set by the three multiplier ranks
// (axis products, projection products, radius products) and the final
// radius sum and compare. The output register and per-stage valid bits let
// words keep entering into empty stages while a result waits.
`timescale 1ns / 1ps

module oriented_rect_overlap_sat #(
    parameter int COORD_BITS     = ors_pkg::COORD_BITS_DEF,
    parameter int AXIS_FRAC_BITS = ors_pkg::AXIS_FRAC_BITS_DEF,
    localparam int CW   = COORD_BITS,
    localparam int HW   = COORD_BITS - 1,
    localparam int AW   = AXIS_FRAC_BITS + 2,
    localparam int RECT = 2 * CW + 2 * HW + 2 * AW,
    localparam int TDW  = ((2 * RECT + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    // a_center_x, a_center_y, a_half_w, a_half_h, a_axis_cos, a_axis_sin,
    // b_center_x, b_center_y, b_half_w, b_half_h, b_axis_cos, b_axis_sin
    input  logic [TDW-1:0] s_axis_tdata,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    // overlap, then zero fill
    output logic [7:0]     m_axis_tdata
);

    localparam int DW = COORD_BITS + 1;
    localparam int MW = DW + AW;
    localparam int RW = AXIS_FRAC_BITS + 4;

    // field offsets within one rectangle
    localparam int O_CX = 0;
    localparam int O_CY = CW;
    localparam int O_HW = 2 * CW;
    localparam int O_HH = 2 * CW + HW;
    localparam int O_AC = 2 * CW + 2 * HW;
    localparam int O_AS = 2 * CW + 2 * HW + AW;

    // unpack the input word
    logic signed [CW-1:0] w_acx, w_acy, w_bcx, w_bcy;
    logic        [HW-1:0] w_ahw, w_ahh, w_bhw, w_bhh;
    logic signed [AW-1:0] w_ac, w_as, w_bc, w_bs;

    assign w_acx = $signed(s_axis_tdata[O_CX +: CW]);
    assign w_acy = $signed(s_axis_tdata[O_CY +: CW]);
    assign w_ahw = s_axis_tdata[O_HW +: HW];
    assign w_ahh = s_axis_tdata[O_HH +: HW];
    assign w_ac  = $signed(s_axis_tdata[O_AC +: AW]);
    assign w_as  = $signed(s_axis_tdata[O_AS +: AW]);
    assign w_bcx = $signed(s_axis_tdata[RECT + O_CX +: CW]);
    assign w_bcy = $signed(s_axis_tdata[RECT + O_CY +: CW]);
    assign w_bhw = s_axis_tdata[RECT + O_HW +: HW];
    assign w_bhh = s_axis_tdata[RECT + O_HH +: HW];
    assign w_bc  = $signed(s_axis_tdata[RECT + O_AC +: AW]);
    assign w_bs  = $signed(s_axis_tdata[RECT + O_AS +: AW]);

    // between the two units
    logic                 w_d_valid, w_d_ready;
    logic        [HW-1:0] w_d_ahw, w_d_ahh, w_d_bhw, w_d_bhh;
    logic        [RW-1:0] w_rna, w_rnb, w_rp, w_rq;
    logic signed [MW-1:0] w_m_dxac, w_m_dyas, w_m_dxas, w_m_dyac;
    logic signed [MW-1:0] w_m_dxbc, w_m_dybs, w_m_dxbs, w_m_dybc;
    logic                 w_overlap;

    ors_dot_unit #(
        .COORD_BITS     (COORD_BITS),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_dot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_acx    (w_acx),
        .i_acy    (w_acy),
        .i_ahw    (w_ahw),
        .i_ahh    (w_ahh),
        .i_ac     (w_ac),
        .i_as     (w_as),
        .i_bcx    (w_bcx),
        .i_bcy    (w_bcy),
        .i_bhw    (w_bhw),
        .i_bhh    (w_bhh),
        .i_bc     (w_bc),
        .i_bs     (w_bs),
        .o_valid  (w_d_valid),
        .i_ready  (w_d_ready),
        .o_ahw    (w_d_ahw),
        .o_ahh    (w_d_ahh),
        .o_bhw    (w_d_bhw),
        .o_bhh    (w_d_bhh),
        .o_rna    (w_rna),
        .o_rnb    (w_rnb),
        .o_rp     (w_rp),
        .o_rq     (w_rq),
        .o_m_dxac (w_m_dxac),
        .o_m_dyas (w_m_dyas),
        .o_m_dxas (w_m_dxas),
        .o_m_dyac (w_m_dyac),
        .o_m_dxbc (w_m_dxbc),
        .o_m_dybs (w_m_dybs),
        .o_m_dxbs (w_m_dxbs),
        .o_m_dybc (w_m_dybc)
    );

    ors_sep_unit #(
        .COORD_BITS     (COORD_BITS),
        .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
    ) u_sep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_d_valid),
        .o_ready   (w_d_ready),
        .i_ahw     (w_d_ahw),
        .i_ahh     (w_d_ahh),
        .i_bhw     (w_d_bhw),
        .i_bhh     (w_d_bhh),
        .i_rna     (w_rna),
        .i_rnb     (w_rnb),
        .i_rp      (w_rp),
        .i_rq      (w_rq),
        .i_m_dxac  (w_m_dxac),
        .i_m_dyas  (w_m_dyas),
        .i_m_dxas  (w_m_dxas),
        .i_m_dyac  (w_m_dyac),
        .i_m_dxbc  (w_m_dxbc),
        .i_m_dybs  (w_m_dybs),
        .i_m_dxbs  (w_m_dxbs),
        .i_m_dybc  (w_m_dybc),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_overlap (w_overlap)
    );

    // pack the result word
    assign m_axis_tdata = {7'd0, w_overlap};

endmodule

### verif/ors_checker.sv
// ---------------------------------------------------------------------------
// ors_checker
// Watches both stream channels of the rectangle overlap block, predicts the
// overlap flag of every accepted pair and compares it with each result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ors_checker #(
    parameter int COORD_BITS     = ors_pkg::COORD_BITS_DEF,
    parameter int AXIS_FRAC_BITS = ors_pkg::AXIS_FRAC_BITS_DEF,
    localparam int CW   = COORD_BITS,
    localparam int HW   = COORD_BITS - 1,
    localparam int AW   = AXIS_FRAC_BITS + 2,
    localparam int RECT = 2 * CW + 2 * HW + 2 * AW,
    localparam int TDW  = ((2 * RECT + 7) / 8) * 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    // a_center_x, a_center_y, a_half_w, a_half_h, a_axis_cos, a_axis_sin,
    // b_center_x, b_center_y, b_half_w, b_half_h, b_axis_cos, b_axis_sin
    input  logic [TDW-1:0] i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    // overlap, then zero fill
    input  logic [7:0]     i_out_data,
    output int             o_errors,
    output int             o_pending
);

    localparam int FILL = TDW - 2 * RECT;
    localparam int MAX_REPORTS = 10;

    // input word layout; first member sits in the top bits
    typedef struct packed {
        logic [FILL-1:0]      fill;
        logic signed [AW-1:0] b_axis_sin;
        logic signed [AW-1:0] b_axis_cos;
        logic [HW-1:0]        b_half_h;
        logic [HW-1:0]        b_half_w;
        logic signed [CW-1:0] b_center_y;
        logic signed [CW-1:0] b_center_x;
        logic signed [AW-1:0] a_axis_sin;
        logic signed [AW-1:0] a_axis_cos;
        logic [HW-1:0]        a_half_h;
        logic [HW-1:0]        a_half_w;
        logic signed [CW-1:0] a_center_y;
        logic signed [CW-1:0] a_center_x;
    } t_rect_pair;

    logic overlap_due [$];
    logic want_overlap;
    int   mismatch_count = 0;
    int   result_index = 0;

    // |v.u| brought back to axis scale, rounded half up
    function automatic longint axis_overlap_len(input longint vx, input longint vy,
                                                input longint ux, input longint uy);
        longint dot;
        dot = vx * ux + vy * uy;
        if (dot < 0)
            dot = -dot;
        return (dot + (64'sd1 <<< (AXIS_FRAC_BITS - 1))) >>> AXIS_FRAC_BITS;
    endfunction

    // separating axis test over the two axes of each rectangle
    function automatic logic predict_overlap(input t_rect_pair p);
        longint ux [4];
        longint uy [4];
        longint dx, dy, ahw, ahh, bhw, bhh;
        longint gap, radius;
        logic   hit;
        dx  = longint'($signed(p.a_center_x)) - longint'($signed(p.b_center_x));
        dy  = longint'($signed(p.a_center_y)) - longint'($signed(p.b_center_y));
        ahw = p.a_half_w;
        ahh = p.a_half_h;
        bhw = p.b_half_w;
        bhh = p.b_half_h;
        ux[0] = $signed(p.a_axis_cos);
        uy[0] = $signed(p.a_axis_sin);
        ux[1] = -uy[0];
        uy[1] = ux[0];
        ux[2] = $signed(p.b_axis_cos);
        uy[2] = $signed(p.b_axis_sin);
        ux[3] = -uy[2];
        uy[3] = ux[2];
        hit = 1'b1;
        for (int k = 0; k < 4; k++) begin
            gap = dx * ux[k] + dy * uy[k];
            if (gap < 0)
                gap = -gap;
            radius = ahw * axis_overlap_len(ux[0], uy[0], ux[k], uy[k])
                   + ahh * axis_overlap_len(ux[1], uy[1], ux[k], uy[k])
                   + bhw * axis_overlap_len(ux[2], uy[2], ux[k], uy[k])
                   + bhh * axis_overlap_len(ux[3], uy[3], ux[k], uy[k]);
            // touching is still overlap
            if (gap > radius)
                hit = 1'b0;
        end
        return hit;
    endfunction

    task automatic log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // result side first, so a word accepted on this edge is queued behind
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                if (overlap_due.size() == 0) begin
                    log_failure($sformatf("result %0d: word %02h with nothing pending",
                                          result_index, i_out_data));
                end else begin
                    want_overlap = overlap_due.pop_front();
                    if (i_out_data !== {7'b0, want_overlap})
                        log_failure($sformatf("result %0d: expected %02h, got %02h",
                                              result_index, {7'b0, want_overlap},
                                              i_out_data));
                end
                result_index++;
            end
            if (i_in_valid && i_in_ready)
                overlap_due.push_back(predict_overlap(t_rect_pair'(i_in_data)));
        end
        o_pending <= overlap_due.size();
        o_errors  <= mismatch_count;
    end

endmodule

### verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the oriented rectangle overlap block: directed
// edge cases, then random rectangle pairs with random idling on both sides
// and one long output hold-off; checking is left to ors_checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int CW   = ors_pkg::COORD_BITS_DEF;
    localparam int HW   = CW - 1;
    localparam int AW   = ors_pkg::AXIS_FRAC_BITS_DEF + 2;
    localparam int RECT = 2 * CW + 2 * HW + 2 * AW;
    localparam int TDW  = ((2 * RECT + 7) / 8) * 8;

    localparam int RANDOM_PAIRS = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;

    // axis components in Q1.14
    localparam int UNIT = 16384;
    localparam int DIAG = 11585;
    localparam int AXIS_MIN = -32768;
    localparam int AXIS_MAX = 32767;
    localparam int COORD_MAX = 8388607;
    localparam int COORD_MIN = -8388608;
    localparam int HALF_MAX = 8388607;

    logic           i_clk;
    logic           i_rst_n;
    logic           s_axis_tvalid;
    logic           s_axis_tready;
    logic [TDW-1:0] s_axis_tdata;
    logic           m_axis_tvalid;
    logic           m_axis_tready;
    logic [7:0]     m_axis_tdata;

    int error_count;
    int pending_count;
    int cycle_count = 0;
    int hold_asked = 0;
    int hold_served = 0;
    bit quiet = 1'b0;

    oriented_rect_overlap_sat u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ors_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .o_errors    (error_count),
        .o_pending   (pending_count)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // pack one input word, first field lowest
    function automatic logic [TDW-1:0] pack_pair(
        input int acx, input int acy, input int ahw, input int ahh,
        input int ac, input int as,
        input int bcx, input int bcy, input int bhw, input int bhh,
        input int bc, input int bs);
        return {{(TDW - 2 * RECT){1'b0}},
                AW'(bs), AW'(bc), HW'(bhh), HW'(bhw), CW'(bcy), CW'(bcx),
                AW'(as), AW'(ac), HW'(ahh), HW'(ahw), CW'(acy), CW'(acx)};
    endfunction

    // unit axis at a random angle
    task automatic pick_axis(output int c, output int s);
        real ang;
        ang = real'($urandom_range(35999)) * 3.14159265358979 / 18000.0;
        c = $rtoi($floor(16384.0 * $cos(ang) + 0.5));
        s = $rtoi($floor(16384.0 * $sin(ang) + 0.5));
    endtask

    // odd axis values: zero, most negative, anything at all
    function automatic int odd_axis_comp();
        int k;
        k = $urandom_range(2);
        if (k == 0)
            return 0;
        else if (k == 1)
            return AXIS_MIN;
        return int'($urandom_range(65535)) - 32768;
    endfunction

    // mostly sensible pairs near each other, some near-touching, some noise
    task automatic make_random_pair(output logic [TDW-1:0] w);
        int kind, sc, span;
        int acx, acy, ahw, ahh, ac, as, bcx, bcy, bhw, bhh, bc, bs;
        kind = $urandom_range(99);
        if (kind < 12) begin
            // aligned boxes side by side, gap of -1, 0 or +1 LSB
            ahw = $urandom_range(4096);
            ahh = $urandom_range(4096);
            bhw = $urandom_range(4096);
            bhh = $urandom_range(4096);
            acx = int'($urandom_range(2097152)) - 1048576;
            acy = int'($urandom_range(2097152)) - 1048576;
            span = ahw + bhw + int'($urandom_range(2)) - 1;
            bcx = ($urandom_range(1) != 0) ? acx + span : acx - span;
            bcy = acy + int'($urandom_range(2 * (ahh + bhh))) - (ahh + bhh);
            ac = ($urandom_range(1) != 0) ? UNIT : -UNIT;
            bc = ($urandom_range(1) != 0) ? UNIT : -UNIT;
            as = 0;
            bs = 0;
            w = pack_pair(acx, acy, ahw, ahh, ac, as, bcx, bcy, bhw, bhh, bc, bs);
        end else if (kind < 82) begin
            sc  = $urandom_range(20, 4);
            ahw = $urandom_range(1 << sc);
            ahh = $urandom_range(1 << sc);
            bhw = $urandom_range(1 << sc);
            bhh = $urandom_range(1 << sc);
            acx = int'($urandom_range(4194304)) - 2097152;
            acy = int'($urandom_range(4194304)) - 2097152;
            bcx = acx + int'($urandom_range(6 << sc)) - (3 << sc);
            bcy = acy + int'($urandom_range(6 << sc)) - (3 << sc);
            pick_axis(ac, as);
            pick_axis(bc, bs);
            if (kind >= 72) begin
                if ($urandom_range(1) != 0) begin
                    ac = odd_axis_comp();
                    as = odd_axis_comp();
                end else begin
                    bc = odd_axis_comp();
                    bs = odd_axis_comp();
                end
            end
            w = pack_pair(acx, acy, ahw, ahh, ac, as, bcx, bcy, bhw, bhh, bc, bs);
        end else begin
            w = {$urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom(), $urandom()};
            w[TDW-1:2*RECT] = '0;
        end
    endtask

    // offer one word, idling first at random; returns on the accepting edge
    task automatic offer_pair(input logic [TDW-1:0] w);
        if (!quiet) begin
            while ($urandom_range(99) < 25) begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata  <= {$urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom(), $urandom(), $urandom()};
                @(posedge i_clk);
            end
        end
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // receiver: random back-pressure, plus the long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= 25);
            end
        end
    end

    // stimulus and verdict
    initial begin
        logic [TDW-1:0] word;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // coincident squares, then touching and one LSB apart along x
        offer_pair(pack_pair(0, 0, 256, 256, UNIT, 0, 0, 0, 256, 256, UNIT, 0));
        offer_pair(pack_pair(0, 0, 256, 256, UNIT, 0, 512, 0, 256, 256, UNIT, 0));
        offer_pair(pack_pair(0, 0, 256, 256, UNIT, 0, 513, 0, 256, 256, UNIT, 0));
        offer_pair(pack_pair(0, 0, 256, 256, -UNIT, 0, -513, 0, 256, 256, UNIT, 0));
        // quarter turn: touching along y, then just clear
        offer_pair(pack_pair(0, 0, 300, 40, 0, UNIT, 0, 500, 90, 200, UNIT, 0));
        offer_pair(pack_pair(0, 0, 300, 40, 0, UNIT, 0, 501, 90, 200, UNIT, 0));
        // diamond against a square, clear and overlapping
        offer_pair(pack_pair(0, 0, 256, 256, DIAG, DIAG, 700, 0, 256, 256, UNIT, 0));
        offer_pair(pack_pair(0, 0, 256, 256, DIAG, -DIAG, 600, 0, 256, 256, UNIT, 0));
        // zero axes never separate; one zero side leaves the other's axes
        offer_pair(pack_pair(0, 0, 256, 256, 0, 0, 9000, 9000, 256, 256, 0, 0));
        offer_pair(pack_pair(0, 0, 256, 256, 0, 0, 9000, 0, 256, 256, UNIT, 0));
        // non-unit axes used as they are
        offer_pair(pack_pair(0, 0, 256, 256, AXIS_MIN, AXIS_MIN,
                             600, -600, 256, 256, AXIS_MIN, AXIS_MIN));
        offer_pair(pack_pair(100, 0, 256, 256, AXIS_MAX, AXIS_MAX,
                             -400, 300, 256, 256, AXIS_MIN, AXIS_MAX));
        // extreme corners, zero and full half sizes
        offer_pair(pack_pair(COORD_MAX, COORD_MAX, 0, 0, UNIT, 0,
                             COORD_MIN, COORD_MIN, 0, 0, UNIT, 0));
        offer_pair(pack_pair(COORD_MAX, COORD_MAX, HALF_MAX, HALF_MAX, DIAG, DIAG,
                             COORD_MIN, COORD_MIN, HALF_MAX, HALF_MAX, UNIT, 0));
        offer_pair(pack_pair(COORD_MIN, COORD_MAX, HALF_MAX, 0, AXIS_MIN, AXIS_MAX,
                             COORD_MAX, COORD_MIN, 0, HALF_MAX, AXIS_MAX, AXIS_MIN));
        // point-sized boxes on the same spot touch
        offer_pair(pack_pair(77, -33, 0, 0, UNIT, 0, 77, -33, 0, 0, DIAG, DIAG));
        // all ones, all zeros, alternating bits
        offer_pair(pack_pair(-1, -1, HALF_MAX, HALF_MAX, -1, -1,
                             -1, -1, HALF_MAX, HALF_MAX, -1, -1));
        offer_pair(pack_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        offer_pair(pack_pair(32'h555555, 32'haaaaaa, 32'h2aaaaa, 32'h555555,
                             32'h5555, 32'haaaa, 32'haaaaaa, 32'h555555,
                             32'h555555, 32'h2aaaaa, 32'haaaa, 32'h5555));
        offer_pair(pack_pair(32'haaaaaa, 32'h555555, 32'h555555, 32'h2aaaaa,
                             32'haaaa, 32'h5555, 32'h555555, 32'haaaaaa,
                             32'h2aaaaa, 32'h555555, 32'h5555, 32'haaaa));

        // random pairs; a stretch with no idling and one long output stall
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n == 200)
                quiet = 1'b1;
            if (n == 400)
                quiet = 1'b0;
            if (n == 550)
                hold_asked++;
            make_random_pair(word);
            offer_pair(word);
        end
        s_axis_tvalid <= 1'b0;

        // drain
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/ors_pkg.sv
design/ors_dot_unit.sv
design/ors_sep_unit.sv
design/oriented_rect_overlap_sat.sv
verif/ors_checker.sv
verif/testbench.sv
